### sv/assert_macros.svh
// Assertion macros of the read-ahead window controller datapath.
// Synthesis builds define SYNTH, which empties every macro body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define RAWC_ALWAYS(lbl, ck, rs, expr) \
  lbl: assert property (@(posedge ck) disable iff (rs) (expr)) \
    else $error("%m: check failed");

`define RAWC_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("%m: check failed");

`define RAWC_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define RAWC_ALWAYS(lbl, ck, rs, expr)

`define RAWC_IMPLY(lbl, ck, rs, ante, cons)

`define RAWC_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

### sv/rawc_pkg.sv
// Shared types and constants of the read-ahead window controller.
// No dependencies; used by rawc_ctrl, rawc_dpath and the top level.
`default_nettype none

package rawc_pkg;

  localparam int POS_W      = 40;
  localparam int LEN_W      = 21;
  localparam int CHUNK_LOG  = 16;
  localparam int SLOT_W     = 4;
  localparam int FILL_W     = 5;
  localparam int OFF_W      = 16;
  localparam int CMD_W      = 3;
  localparam int KIND_W     = 3;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = 40;

  localparam logic [FILL_W-1:0] SLOTS       = 5'd16;
  localparam logic [LEN_W-1:0]  CHUNK_BYTES = 21'd65536;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE  = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ, CMD_SEEK, CMD_SKIP, CMD_POLL, CMD_FILL
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEGMENT, KIND_DIRECT, KIND_END, KIND_SEEK_DONE,
    KIND_FETCH, KIND_IDLE, KIND_FILL_OK, KIND_FILL_REJECT
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_RLEN, S_RCHECK, S_SEG,
    S_CLAMP, S_DREL, S_DAPPLY, S_PPREP, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_PREP, OP_RLEN, OP_RCHECK, OP_SEG,
    OP_CLAMP, OP_DREL, OP_DAPPLY, OP_PPREP,
    OP_EMIT_READ, OP_EMIT_SEEK, OP_EMIT_POLL, OP_EMIT_FILL, OP_EMIT_IDLE
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             enable;
    logic             hit;
    logic             seg_last;
    logic             out_free;
  } status_t;

endpackage

`default_nettype wire

### sv/rawc_ctrl.sv
// Sequencer of the read-ahead window controller: steps each item through
// its datapath operations. Depends on rawc_pkg.
`default_nettype none

module rawc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire rawc_pkg::status_t status,
  output rawc_pkg::op_t         op
);

  rawc_pkg::state_t state;
  rawc_pkg::state_t state_next;
  rawc_pkg::op_t    emit_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rawc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (status.cmd)
      rawc_pkg::CMD_READ: begin
        emit_op = rawc_pkg::OP_EMIT_READ;
      end
      rawc_pkg::CMD_SEEK, rawc_pkg::CMD_SKIP: begin
        emit_op = rawc_pkg::OP_EMIT_SEEK;
      end
      rawc_pkg::CMD_POLL: begin
        emit_op = status.enable ? rawc_pkg::OP_EMIT_POLL : rawc_pkg::OP_EMIT_IDLE;
      end
      rawc_pkg::CMD_FILL: begin
        emit_op = rawc_pkg::OP_EMIT_FILL;
      end
      default: begin
        emit_op = rawc_pkg::OP_EMIT_IDLE;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      rawc_pkg::S_IDLE: begin
        if (s_tvalid) state_next = rawc_pkg::S_PREP;
      end
      rawc_pkg::S_PREP: begin
        case (status.cmd)
          rawc_pkg::CMD_READ: begin
            state_next = rawc_pkg::S_RLEN;
          end
          rawc_pkg::CMD_SEEK, rawc_pkg::CMD_SKIP: begin
            state_next = rawc_pkg::S_CLAMP;
          end
          rawc_pkg::CMD_POLL: begin
            state_next = status.enable ? rawc_pkg::S_DAPPLY : rawc_pkg::S_EMIT;
          end
          default: begin
            state_next = rawc_pkg::S_EMIT;
          end
        endcase
      end
      rawc_pkg::S_RLEN: begin
        state_next = rawc_pkg::S_RCHECK;
      end
      rawc_pkg::S_RCHECK: begin
        state_next = status.hit ? rawc_pkg::S_SEG : rawc_pkg::S_EMIT;
      end
      rawc_pkg::S_SEG: begin
        if (status.out_free && status.seg_last) state_next = rawc_pkg::S_IDLE;
      end
      rawc_pkg::S_CLAMP: begin
        state_next = rawc_pkg::S_DREL;
      end
      rawc_pkg::S_DREL: begin
        state_next = rawc_pkg::S_DAPPLY;
      end
      rawc_pkg::S_DAPPLY: begin
        state_next = (status.cmd == rawc_pkg::CMD_POLL) ? rawc_pkg::S_PPREP
                                                        : rawc_pkg::S_EMIT;
      end
      rawc_pkg::S_PPREP: begin
        state_next = rawc_pkg::S_EMIT;
      end
      rawc_pkg::S_EMIT: begin
        if (status.out_free) state_next = rawc_pkg::S_IDLE;
      end
      default: begin
        state_next = rawc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    op       = rawc_pkg::OP_NONE;
    case (state)
      rawc_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) op = rawc_pkg::OP_CAPTURE;
      end
      rawc_pkg::S_PREP: begin
        op = rawc_pkg::OP_PREP;
      end
      rawc_pkg::S_RLEN: begin
        op = rawc_pkg::OP_RLEN;
      end
      rawc_pkg::S_RCHECK: begin
        op = rawc_pkg::OP_RCHECK;
      end
      rawc_pkg::S_SEG: begin
        if (status.out_free) op = rawc_pkg::OP_SEG;
      end
      rawc_pkg::S_CLAMP: begin
        op = rawc_pkg::OP_CLAMP;
      end
      rawc_pkg::S_DREL: begin
        op = rawc_pkg::OP_DREL;
      end
      rawc_pkg::S_DAPPLY: begin
        op = rawc_pkg::OP_DAPPLY;
      end
      rawc_pkg::S_PPREP: begin
        op = rawc_pkg::OP_PPREP;
      end
      rawc_pkg::S_EMIT: begin
        if (status.out_free) op = emit_op;
      end
      default: begin
        op = rawc_pkg::OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/rawc_dpath.sv
// Datapath of the read-ahead window controller: window state, item fields,
// working registers and the result register. Depends on rawc_pkg and
// assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module rawc_dpath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire rawc_pkg::op_t                    op,
  output rawc_pkg::status_t                     status,
  input  wire logic [rawc_pkg::IN_DATA_W-1:0]   s_tdata,
  input  wire logic [rawc_pkg::CMD_W-1:0]       s_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [rawc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rawc_pkg::CFG_W-1:0]       cfg_data,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [rawc_pkg::OUT_DATA_W-1:0]       m_tdata,
  output logic [rawc_pkg::KIND_W-1:0]           m_tuser,
  output logic                                  m_tlast
);

  // Window state and registers.
  logic [rawc_pkg::POS_W-1:0]  cursor;
  logic [rawc_pkg::POS_W-1:0]  base;
  logic [rawc_pkg::SLOT_W-1:0] head;
  logic [rawc_pkg::FILL_W-1:0] filled;
  logic                        en;
  logic [rawc_pkg::POS_W-1:0]  space;

  // Fields of the item at work.
  logic [rawc_pkg::CMD_W-1:0]  cmd;
  logic [rawc_pkg::LEN_W-1:0]  len;
  logic [rawc_pkg::POS_W-1:0]  target;
  logic [rawc_pkg::POS_W:0]    delta;
  logic [rawc_pkg::POS_W-1:0]  fpos;
  logic                        fok;

  // Working registers.
  logic [rawc_pkg::POS_W:0]    rel;
  logic [rawc_pkg::POS_W-1:0]  rem;
  logic                        at_end;
  logic [rawc_pkg::POS_W:0]    tgt;
  logic                        fill_match;
  logic [rawc_pkg::LEN_W-1:0]  len_c;
  logic [rawc_pkg::OFF_W-1:0]  seg_off;
  logic [rawc_pkg::SLOT_W-1:0] seg_slot;
  logic [rawc_pkg::POS_W:0]    ppos;

  // Result register.
  logic                        o_valid;
  logic [rawc_pkg::KIND_W-1:0] o_kind;
  logic [rawc_pkg::SLOT_W-1:0] o_slot;
  logic [rawc_pkg::OFF_W-1:0]  o_off;
  logic [rawc_pkg::POS_W-1:0]  o_pos;
  logic [rawc_pkg::LEN_W-1:0]  o_cnt;
  logic                        o_last;

  logic [rawc_pkg::POS_W-1:0]  cursor_floor;
  logic [rawc_pkg::POS_W:0]    rel_now;
  logic [rawc_pkg::POS_W+1:0]  skip_sum;
  logic [rawc_pkg::POS_W:0]    window_end;
  logic [rawc_pkg::POS_W:0]    hit_sum;
  logic                        hit_now;
  logic [rawc_pkg::LEN_W-1:0]  seg_room;
  logic [rawc_pkg::LEN_W-1:0]  take;
  logic                        seg_last;
  logic [rawc_pkg::POS_W-17:0] used_chunks;
  logic [rawc_pkg::FILL_W-1:0] drop_n;
  logic [rawc_pkg::FILL_W-1:0] fill_left;
  logic [rawc_pkg::POS_W+1:0]  poll_gap;
  logic                        can_fetch;
  logic [rawc_pkg::LEN_W-1:0]  want;
  logic                        fill_ok;
  logic                        is_emit;
  logic                        out_free;

  rawc_pkg::kind_t             e_kind;
  logic [rawc_pkg::SLOT_W-1:0] e_slot;
  logic [rawc_pkg::OFF_W-1:0]  e_off;
  logic [rawc_pkg::POS_W-1:0]  e_pos;
  logic [rawc_pkg::LEN_W-1:0]  e_cnt;
  logic                        e_last;

  always_comb begin
    cursor_floor = {cursor[rawc_pkg::POS_W-1:rawc_pkg::CHUNK_LOG],
                    {rawc_pkg::CHUNK_LOG{1'b0}}};
    rel_now      = {1'b0, cursor} - {1'b0, base};
    skip_sum     = {2'b00, cursor} + {delta[rawc_pkg::POS_W], delta};
    window_end   = {20'd0, filled, {rawc_pkg::CHUNK_LOG{1'b0}}};
    hit_sum      = rel + {20'd0, len_c};
    hit_now      = !at_end && (len_c != '0) && en && (filled != '0) &&
                   !rel[rawc_pkg::POS_W] && (hit_sum <= window_end);
    seg_room     = rawc_pkg::CHUNK_BYTES - {5'd0, seg_off};
    take         = (seg_room < len_c) ? seg_room : len_c;
    seg_last     = (take == len_c);
    used_chunks  = rel[rawc_pkg::POS_W-1:rawc_pkg::CHUNK_LOG];
    drop_n       = (used_chunks >= {19'd0, filled}) ? filled : used_chunks[4:0];
    fill_left    = filled - drop_n;
    poll_gap     = {2'b00, space} - {1'b0, ppos};
    can_fetch    = (filled < rawc_pkg::SLOTS) && !poll_gap[rawc_pkg::POS_W+1] &&
                   (poll_gap != '0);
    want         = (poll_gap >= {21'd0, rawc_pkg::CHUNK_BYTES}) ? rawc_pkg::CHUNK_BYTES
                                                             : poll_gap[20:0];
    fill_ok      = fok && en && (filled < rawc_pkg::SLOTS) && fill_match;
    out_free     = !o_valid || m_tready;
  end

  always_comb begin
    is_emit = 1'b1;
    e_kind  = rawc_pkg::KIND_IDLE;
    e_slot  = '0;
    e_off   = '0;
    e_pos   = '0;
    e_cnt   = '0;
    e_last  = 1'b1;
    case (op)
      rawc_pkg::OP_SEG: begin
        e_kind = rawc_pkg::KIND_SEGMENT;
        e_slot = seg_slot;
        e_off  = seg_off;
        e_pos  = cursor;
        e_cnt  = take;
        e_last = seg_last;
      end
      rawc_pkg::OP_EMIT_READ: begin
        e_pos = cursor;
        if (at_end) begin
          e_kind = rawc_pkg::KIND_END;
        end else begin
          e_kind = rawc_pkg::KIND_DIRECT;
          e_cnt  = len_c;
        end
      end
      rawc_pkg::OP_EMIT_SEEK: begin
        e_kind = rawc_pkg::KIND_SEEK_DONE;
        e_pos  = cursor;
      end
      rawc_pkg::OP_EMIT_POLL: begin
        if (can_fetch) begin
          e_kind = rawc_pkg::KIND_FETCH;
          e_slot = head + filled[rawc_pkg::SLOT_W-1:0];
          e_pos  = ppos[rawc_pkg::POS_W-1:0];
          e_cnt  = want;
        end
      end
      rawc_pkg::OP_EMIT_FILL: begin
        e_kind = fill_ok ? rawc_pkg::KIND_FILL_OK : rawc_pkg::KIND_FILL_REJECT;
        e_pos  = fpos;
      end
      rawc_pkg::OP_EMIT_IDLE: begin
        e_kind = rawc_pkg::KIND_IDLE;
      end
      default: begin
        is_emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      base   <= '0;
      head   <= '0;
      filled <= '0;
      en     <= 1'b0;
      space  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rawc_pkg::CFG_ENABLE: begin
            en <= cfg_data[0];
            if (!cfg_data[0]) begin
              filled <= '0;
              head   <= '0;
              base   <= cursor_floor;
            end
          end
          rawc_pkg::CFG_SPACE: begin
            space <= cfg_data;
          end
          default: begin
          end
        endcase
      end
      case (op)
        rawc_pkg::OP_SEG: begin
          cursor <= cursor + {19'd0, take};
        end
        rawc_pkg::OP_EMIT_READ: begin
          if (!at_end) cursor <= cursor + {19'd0, len_c};
        end
        rawc_pkg::OP_CLAMP: begin
          cursor <= (tgt > {1'b0, space}) ? space : tgt[rawc_pkg::POS_W-1:0];
        end
        rawc_pkg::OP_DAPPLY: begin
          if (rel[rawc_pkg::POS_W]) begin
            base   <= cursor_floor;
            head   <= '0;
            filled <= '0;
          end else begin
            filled <= fill_left;
            head   <= head + drop_n[rawc_pkg::SLOT_W-1:0];
            base   <= (fill_left == '0) ? cursor_floor
                    : base + {19'd0, drop_n, {rawc_pkg::CHUNK_LOG{1'b0}}};
          end
        end
        rawc_pkg::OP_EMIT_FILL: begin
          if (fill_ok) filled <= filled + 5'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      rawc_pkg::OP_CAPTURE: begin
        cmd    <= s_tuser;
        len    <= s_tdata[20:0];
        target <= s_tdata[60:21];
        delta  <= s_tdata[101:61];
        fpos   <= s_tdata[141:102];
        fok    <= s_tdata[142];
      end
      rawc_pkg::OP_PREP: begin
        rel        <= rel_now;
        at_end     <= (cursor >= space);
        rem        <= space - cursor;
        tgt        <= (cmd == rawc_pkg::CMD_SEEK) ? {1'b0, target}
                    : (skip_sum[rawc_pkg::POS_W+1] ? '0 : skip_sum[rawc_pkg::POS_W:0]);
        fill_match <= ({1'b0, base} + window_end) == {1'b0, fpos};
      end
      rawc_pkg::OP_DREL: begin
        rel <= rel_now;
      end
      rawc_pkg::OP_RLEN: begin
        len_c <= ({19'd0, len} > rem) ? rem[20:0] : len;
      end
      rawc_pkg::OP_RCHECK: begin
        seg_off  <= rel[rawc_pkg::OFF_W-1:0];
        seg_slot <= head + rel[rawc_pkg::CHUNK_LOG+rawc_pkg::SLOT_W-1:rawc_pkg::CHUNK_LOG];
      end
      rawc_pkg::OP_SEG: begin
        len_c    <= len_c - take;
        seg_off  <= '0;
        seg_slot <= seg_slot + 4'd1;
      end
      rawc_pkg::OP_PPREP: begin
        ppos <= {1'b0, base} + window_end;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (is_emit) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_emit) begin
      o_kind <= e_kind;
      o_slot <= e_slot;
      o_off  <= e_off;
      o_pos  <= e_pos;
      o_cnt  <= e_cnt;
      o_last <= e_last;
    end
  end

  always_comb begin
    status.cmd      = cmd;
    status.enable   = en;
    status.hit      = hit_now;
    status.seg_last = seg_last;
    status.out_free = out_free;
    m_tvalid        = o_valid;
    m_tdata         = {7'd0, o_cnt, o_pos, o_off, o_slot};
    m_tuser         = o_kind;
    m_tlast         = o_last;
  end

  `RAWC_ALWAYS(a_filled_bound, clk, rst, filled <= rawc_pkg::SLOTS)
  `RAWC_ALWAYS(a_base_aligned, clk, rst, base[rawc_pkg::CHUNK_LOG-1:0] == '0)
  `RAWC_IMPLY(a_emit_has_room, clk, rst, is_emit, !o_valid || m_tready)
  `RAWC_NEXT(a_fill_counts, clk, rst, (op == rawc_pkg::OP_EMIT_FILL) && fill_ok && !cfg_we, filled == $past(filled) + 5'd1)

endmodule

`default_nettype wire

### sv/read_ahead_window_controller.sv
// Top level of the read-ahead window controller: sequencer and datapath.
// Depends on rawc_pkg, rawc_ctrl and rawc_dpath.
//
//   port group   dir   role                tdata (low bit up)                  tuser
//   s_*          in    command items       length, target, skip, fetched pos,  command
//                                          fetch ok
//   m_*          out   result items        slot, chunk offset, position,       result kind
//                                          byte count (tlast = final result)
//   cfg_*        in    register writes     index 0 enable, index 1 space size
//
// An item is taken in the idle state and then runs through the datapath
// sequence: a fill completion or unknown command through prep and emit; a poll
// through prep, retire, fetch prep and emit (prep and emit with read-ahead off);
// a read through prep, length clamp and hit check, then its segments on a hit or
// one result; a seek or skip through prep, clamp, relative position, retire and
// emit. Each result waits until the output register is free. Synchronous reset
// clears the cursor, window and registers; no clearing pass follows. Register
// writes must come only while the block is idle; the block leaves this to the user.
`default_nettype none

module read_ahead_window_controller (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // request_length[20:0], target_position[60:21], skip_delta[101:61],
  // fetched_position[141:102], fetch_complete_ok[142], zero pad[143]
  input  wire logic [rawc_pkg::IN_DATA_W-1:0]   s_tdata,
  // command[2:0]
  input  wire logic [rawc_pkg::CMD_W-1:0]       s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // slot_index[3:0], chunk_offset[19:4], byte_position[59:20],
  // byte_count[80:60], zero pad[87:81]
  output logic [rawc_pkg::OUT_DATA_W-1:0]       m_tdata,
  // result_kind[2:0]
  output logic [rawc_pkg::KIND_W-1:0]           m_tuser,
  output logic                                  m_tlast,
  input  wire logic                             cfg_we,
  input  wire logic [rawc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rawc_pkg::CFG_W-1:0]       cfg_data
);

  rawc_pkg::op_t     op;
  rawc_pkg::status_t status;

  rawc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .op       (op)
  );

  rawc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

### tb/window_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the read-ahead window controller testbench.
// Keeps its own copy of the cursor, the ring window and the registers, predicts
// the results of every accepted command and compares them in order. Uses rawc_pkg.
module window_result_checker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  input  wire logic                              s_tready,
  input  wire logic [rawc_pkg::IN_DATA_W-1:0]    s_tdata,
  input  wire logic [rawc_pkg::CMD_W-1:0]        s_tuser,
  input  wire logic                              m_tvalid,
  input  wire logic                              m_tready,
  input  wire logic [rawc_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  wire logic [rawc_pkg::KIND_W-1:0]       m_tuser,
  input  wire logic                              m_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [rawc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rawc_pkg::CFG_W-1:0]        cfg_data,
  output int                                     mismatches,
  output int                                     outstanding
);

  localparam logic [63:0] CHUNK = 64'(rawc_pkg::CHUNK_BYTES);
  localparam int MAX_SEGMENTS = 17;

  typedef struct packed {
    rawc_pkg::kind_t             kind;
    logic [rawc_pkg::SLOT_W-1:0] slot;
    logic [rawc_pkg::OFF_W-1:0]  offset;
    logic [rawc_pkg::POS_W-1:0]  position;
    logic [rawc_pkg::LEN_W-1:0]  count;
    logic                        last;
  } result_t;

  logic [rawc_pkg::POS_W-1:0]  cursor;
  logic [rawc_pkg::POS_W-1:0]  base;
  logic [rawc_pkg::POS_W-1:0]  space;
  logic [rawc_pkg::SLOT_W-1:0] head;
  logic [rawc_pkg::FILL_W-1:0] filled;
  logic                        enable;
  result_t                     expected_results[$];

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  function automatic logic [rawc_pkg::POS_W-1:0] chunk_floor(
      input logic [rawc_pkg::POS_W-1:0] v);
    return {v[rawc_pkg::POS_W-1:rawc_pkg::CHUNK_LOG], {rawc_pkg::CHUNK_LOG{1'b0}}};
  endfunction

  task automatic push_result(input rawc_pkg::kind_t k, input logic [63:0] slot,
                             input logic [63:0] off, input logic [63:0] pos,
                             input logic [63:0] cnt, input logic last);
    result_t r;
    r.kind     = k;
    r.slot     = slot[rawc_pkg::SLOT_W-1:0];
    r.offset   = off[rawc_pkg::OFF_W-1:0];
    r.position = pos[rawc_pkg::POS_W-1:0];
    r.count    = cnt[rawc_pkg::LEN_W-1:0];
    r.last     = last;
    expected_results.push_back(r);
  endtask

  // Chunks wholly behind the cursor leave the window; a cursor behind the
  // window restarts it empty at the cursor's chunk.
  task automatic retire_consumed();
    if (cursor < base) begin
      base = chunk_floor(cursor);
      head = '0;
      filled = '0;
    end else begin
      while (filled != 0 && 64'(base) + CHUNK <= 64'(cursor)) begin
        base = base + CHUNK[rawc_pkg::POS_W-1:0];
        head = head + 1'b1;
        filled = filled - 1'b1;
      end
      if (filled == 0) begin
        base = chunk_floor(cursor);
      end
    end
  endtask

  task automatic serve_read(input logic [63:0] len);
    logic [63:0] stop;
    logic [63:0] first;
    logic [63:0] final_chunk;
    logic [63:0] rel;
    logic [63:0] take;
    if (cursor >= space) begin
      push_result(rawc_pkg::KIND_END, 0, 0, 64'(cursor), 0, 1'b1);
      return;
    end
    if (64'(cursor) + len > 64'(space)) begin
      len = 64'(space) - 64'(cursor);
    end
    stop = 64'(base) + 64'(filled) * CHUNK;
    if (len != 0 && enable && filled != 0 && cursor >= base &&
        64'(cursor) + len <= stop) begin
      first = (64'(cursor) - 64'(base)) / CHUNK;
      final_chunk = (64'(cursor) + len - 64'd1 - 64'(base)) / CHUNK;
      if (final_chunk - first + 64'd1 <= MAX_SEGMENTS) begin
        while (len != 0) begin
          rel = 64'(cursor) - 64'(base);
          take = CHUNK - rel % CHUNK;
          if (take > len) begin
            take = len;
          end
          len = len - take;
          push_result(rawc_pkg::KIND_SEGMENT, 64'(head) + rel / CHUNK, rel % CHUNK,
                      64'(cursor), take, len == 0);
          cursor = cursor + take[rawc_pkg::POS_W-1:0];
        end
        return;
      end
    end
    push_result(rawc_pkg::KIND_DIRECT, 0, 0, 64'(cursor), len, 1'b1);
    cursor = cursor + len[rawc_pkg::POS_W-1:0];
  endtask

  task automatic move_cursor(input logic [63:0] target);
    if (target > 64'(space)) begin
      target = 64'(space);
    end
    cursor = target[rawc_pkg::POS_W-1:0];
    retire_consumed();
    push_result(rawc_pkg::KIND_SEEK_DONE, 0, 0, 64'(cursor), 0, 1'b1);
  endtask

  task automatic issue_fetch();
    logic [63:0] pos;
    logic [63:0] want;
    if (enable) begin
      retire_consumed();
      pos = 64'(base) + 64'(filled) * CHUNK;
      if (filled < rawc_pkg::SLOTS && pos < 64'(space)) begin
        want = CHUNK;
        if (pos + want > 64'(space)) begin
          want = 64'(space) - pos;
        end
        push_result(rawc_pkg::KIND_FETCH, 64'(head) + 64'(filled), 0, pos, want, 1'b1);
        return;
      end
    end
    push_result(rawc_pkg::KIND_IDLE, 0, 0, 0, 0, 1'b1);
  endtask

  task automatic commit_fill(input logic [rawc_pkg::POS_W-1:0] pos, input logic ok_bit);
    logic accept;
    accept = ok_bit && enable && filled < rawc_pkg::SLOTS &&
             64'(base) + 64'(filled) * CHUNK == 64'(pos);
    if (accept) begin
      filled = filled + 1'b1;
      push_result(rawc_pkg::KIND_FILL_OK, 0, 0, 64'(pos), 0, 1'b1);
    end else begin
      push_result(rawc_pkg::KIND_FILL_REJECT, 0, 0, 64'(pos), 0, 1'b1);
    end
  endtask

  task automatic predict_command(input logic [rawc_pkg::CMD_W-1:0] code,
                                 input logic [rawc_pkg::IN_DATA_W-1:0] d);
    logic [40:0]        delta;
    logic signed [63:0] t;
    case (code)
      rawc_pkg::CMD_READ: serve_read(64'(d[20:0]));
      rawc_pkg::CMD_SEEK: move_cursor(64'(d[60:21]));
      rawc_pkg::CMD_SKIP: begin
        delta = d[101:61];
        t = $signed({24'd0, cursor}) + $signed({{23{delta[40]}}, delta});
        if (t < 0) begin
          t = 0;
        end
        move_cursor(t);
      end
      rawc_pkg::CMD_POLL: issue_fetch();
      rawc_pkg::CMD_FILL: commit_fill(d[141:102], d[142]);
      default: push_result(rawc_pkg::KIND_IDLE, 0, 0, 0, 0, 1'b1);
    endcase
  endtask

  task automatic apply_register(input logic [rawc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [rawc_pkg::CFG_W-1:0] value);
    if (idx == rawc_pkg::CFG_ENABLE) begin
      enable = value[0];
      if (!enable) begin
        filled = '0;
        head = '0;
        base = chunk_floor(cursor);
      end
    end else begin
      space = value[rawc_pkg::POS_W-1:0];
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : observe
    result_t want;
    if (rst) begin
      cursor = '0;
      base = '0;
      space = '0;
      head = '0;
      filled = '0;
      enable = 1'b0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result kind %0d at %0h: expected none, actual one", $time,
                   m_tuser, m_tdata[59:20]);
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", 64'(want.kind), 64'(m_tuser));
          check_field("slot_index", 64'(want.slot), 64'(m_tdata[3:0]));
          check_field("chunk_offset", 64'(want.offset), 64'(m_tdata[19:4]));
          check_field("byte_position", 64'(want.position), 64'(m_tdata[59:20]));
          check_field("byte_count", 64'(want.count), 64'(m_tdata[80:60]));
          check_field("last_result", 64'(want.last), 64'(m_tlast));
        end
      end
      if (cfg_we) begin
        apply_register(cfg_index, cfg_data);
      end
      if (s_tvalid && s_tready) begin
        predict_command(s_tuser, s_tdata);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

### tb/read_ahead_window_controller_tb.sv
`timescale 1ns / 100ps
// Top of the read-ahead window controller testbench: clock, reset, command
// stimulus, register writes and output back-pressure. Uses rawc_pkg, the block
// and window_result_checker, which predicts and compares the results.
module read_ahead_window_controller_tb;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic                       pad;
    logic                       fetch_ok;
    logic [rawc_pkg::POS_W-1:0] fetched_pos;
    logic [rawc_pkg::POS_W:0]   skip_delta;
    logic [rawc_pkg::POS_W-1:0] target;
    logic [rawc_pkg::LEN_W-1:0] length;
  } command_fields_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [rawc_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [rawc_pkg::CMD_W-1:0]      s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [rawc_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [rawc_pkg::KIND_W-1:0]     m_tuser;
  logic                            m_tlast;
  logic                            cfg_we = 1'b0;
  logic [rawc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rawc_pkg::CFG_W-1:0]      cfg_data = '0;
  int                              mismatches;
  int                              outstanding;

  int                              cycle_count = 0;
  int                              items_sent = 0;
  int                              burst_left = 0;
  logic [rawc_pkg::POS_W-1:0]      space_now = '0;
  logic [rawc_pkg::KIND_W-1:0]     last_kind = '0;
  logic [rawc_pkg::POS_W-1:0]      last_fetch_pos = '0;

  read_ahead_window_controller dut (.*);
  window_result_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    case (cycle_count[9:8])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_tready <= (cycle_count[2:0] < 3'd3);
      default: m_tready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready && m_tlast) begin
      last_kind <= m_tuser;
      last_fetch_pos <= m_tdata[59:20];
    end
  end

  function automatic logic [rawc_pkg::POS_W-1:0] random_position();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[rawc_pkg::POS_W-1:0];
  endfunction

  function automatic logic [rawc_pkg::POS_W-1:0] position_in_space();
    logic [63:0] r;
    r = 64'(random_position()) % (64'(space_now) + 64'd1);
    return r[rawc_pkg::POS_W-1:0];
  endfunction

  function automatic command_fields_t random_fields();
    command_fields_t f;
    logic [63:0]     r;
    r = {$urandom, $urandom};
    f.length = r[rawc_pkg::LEN_W-1:0];
    f.target = random_position();
    r = {$urandom, $urandom};
    f.skip_delta = r[rawc_pkg::POS_W:0];
    f.fetched_pos = random_position();
    r = {$urandom, $urandom};
    f.fetch_ok = r[0];
    f.pad = 1'b0;
    return f;
  endfunction

  function automatic logic [rawc_pkg::LEN_W-1:0] pick_length();
    int          r;
    logic [31:0] v;
    r = $urandom_range(0, 9);
    if (r < 3) v = $urandom_range(0, 300);
    else if (r < 6) v = $urandom_range(1, 200000);
    else if (r < 8) v = $urandom_range(0, 1048576);
    else if (r == 8) v = ($urandom_range(0, 1) != 0) ? 32'd1048576 : 32'd65536;
    else v = $urandom;
    return v[rawc_pkg::LEN_W-1:0];
  endfunction

  // Items go out in bursts; a burst ends with valid low for a random gap.
  task automatic send_item(input logic [rawc_pkg::CMD_W-1:0] code,
                           input command_fields_t f);
    s_tvalid <= 1'b1;
    s_tdata  <= f;
    s_tuser  <= code;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic send_read(input logic [rawc_pkg::LEN_W-1:0] len);
    command_fields_t f;
    f = random_fields();
    f.length = len;
    send_item(rawc_pkg::CMD_READ, f);
  endtask

  task automatic send_seek(input logic [rawc_pkg::POS_W-1:0] target);
    command_fields_t f;
    f = random_fields();
    f.target = target;
    send_item(rawc_pkg::CMD_SEEK, f);
  endtask

  task automatic send_skip(input logic [rawc_pkg::POS_W:0] delta);
    command_fields_t f;
    f = random_fields();
    f.skip_delta = delta;
    send_item(rawc_pkg::CMD_SKIP, f);
  endtask

  task automatic send_poll();
    send_item(rawc_pkg::CMD_POLL, random_fields());
  endtask

  task automatic send_fill(input logic [rawc_pkg::POS_W-1:0] pos, input logic ok);
    command_fields_t f;
    f = random_fields();
    f.fetched_pos = pos;
    f.fetch_ok = ok;
    send_item(rawc_pkg::CMD_FILL, f);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [rawc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [rawc_pkg::CFG_W-1:0] value);
    drain();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Polls and completes fetches in turn, mostly well formed, until the ring
  // stops offering chunks or the requested number is reached.
  task automatic fill_ring(input int chunks);
    for (int i = 0; i < chunks; i++) begin
      send_poll();
      drain();
      if (last_kind != rawc_pkg::KIND_FETCH) break;
      case ($urandom_range(0, 19))
        0: send_fill(last_fetch_pos, 1'b0);
        1: send_fill(last_fetch_pos + rawc_pkg::CHUNK_BYTES, 1'b1);
        default: send_fill(last_fetch_pos, 1'b1);
      endcase
    end
  endtask

  initial begin
    int                          phase;
    int                          phase_start;
    int                          pick;
    int                          short_skip;
    logic                        en;
    logic [63:0]                 rnd;
    logic [rawc_pkg::CFG_W-1:0]  reg_value;
    logic [rawc_pkg::POS_W-1:0]  target;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty space with read-ahead off.
    send_read(21'd100);
    send_poll();
    send_fill('0, 1'b1);
    for (int c = rawc_pkg::CMD_FILL + 1; c < (1 << rawc_pkg::CMD_W); c++) begin
      send_item(c[rawc_pkg::CMD_W-1:0], random_fields());
    end
    send_seek({rawc_pkg::POS_W{1'b1}});

    space_now = 40'd2098152;
    write_register(rawc_pkg::CFG_SPACE, space_now);
    write_register(rawc_pkg::CFG_ENABLE, 40'd1);
    send_read('0);
    send_poll();
    send_fill('0, 1'b1);
    send_fill(40'd65536, 1'b0);
    send_fill(40'd12345, 1'b1);
    send_poll();
    send_fill(40'd65536, 1'b1);
    send_read(21'd100);
    send_read(21'd100000);
    send_read(21'd200000);
    send_skip({1'b1, {rawc_pkg::POS_W{1'b0}}});
    send_skip({1'b0, {rawc_pkg::POS_W{1'b1}}});
    send_read({rawc_pkg::LEN_W{1'b1}});
    send_seek(40'd2098000);
    send_read({rawc_pkg::LEN_W{1'b1}});
    send_poll();
    send_fill(40'd2097152, 1'b1);
    send_poll();

    for (phase = 0; phase < 7; phase++) begin
      en = 1'b1;
      case (phase)
        0: space_now = 40'd3158073;
        1: space_now = {rawc_pkg::POS_W{1'b1}};
        2: begin
          en = 1'b0;
          space_now = random_position() >> $urandom_range(0, 20);
        end
        3: space_now = 40'd777;
        4: space_now = '0;
        5: space_now = 40'd1 + $urandom_range(0, 1 << 26);
        default: space_now = 40'd16777216;
      endcase
      write_register(rawc_pkg::CFG_SPACE, space_now);
      reg_value = random_position();
      reg_value[0] = en;
      write_register(rawc_pkg::CFG_ENABLE, reg_value);

      phase_start = items_sent;
      while (items_sent - phase_start < 50) begin
        pick = $urandom_range(0, 19);
        if (pick < 7) begin
          fill_ring($urandom_range(1, 17));
          repeat ($urandom_range(1, 4)) send_read(pick_length());
        end else if (pick < 11) begin
          repeat ($urandom_range(1, 5)) send_read(pick_length());
        end else if (pick < 14) begin
          case ($urandom_range(0, 7))
            0: send_seek(position_in_space());
            1: send_seek(space_now + $urandom_range(1, 5000));
            2: send_seek(random_position());
            3: send_seek('0);
            4: begin
              short_skip = $urandom_range(0, 400000) - 200000;
              send_skip({{9{short_skip[31]}}, short_skip});
            end
            5: send_skip({1'b1, {rawc_pkg::POS_W{1'b0}}});
            6: send_skip({1'b0, {rawc_pkg::POS_W{1'b1}}});
            default: begin
              rnd = {$urandom, $urandom};
              send_skip(rnd[rawc_pkg::POS_W:0]);
            end
          endcase
        end else if (pick < 16) begin
          target = position_in_space();
          target[rawc_pkg::CHUNK_LOG-1:0] = '0;
          send_seek(target);
          fill_ring(16);
          send_read(($urandom_range(0, 1) != 0) ? 21'd1048576 : pick_length());
        end else if (pick < 18) begin
          rnd = {$urandom, $urandom};
          send_item(rnd[rawc_pkg::CMD_W-1:0], random_fields());
        end else begin
          repeat ($urandom_range(1, 3)) send_poll();
        end
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/rawc_pkg.sv
sv/rawc_ctrl.sv
sv/rawc_dpath.sv
sv/read_ahead_window_controller.sv
tb/window_result_checker.sv
tb/read_ahead_window_controller_tb.sv
